[rtl/owb_pkg.sv]
// Shared types, codes and constants of the one-wire bus master.
package owb_pkg;

   localparam int unsigned TIMER_W   = 12;
   localparam int unsigned CSR_W     = 10;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned BITCNT_W  = 4;

   localparam logic [CSR_W-1:0] RESET_LOW_INIT      = 10'd490;
   localparam logic [CSR_W-1:0] PRESENCE_INIT       = 10'd40;
   localparam logic [CSR_W-1:0] RESET_RECOVERY_INIT = 10'd450;
   localparam logic [CSR_W-1:0] WRITE_ONE_INIT      = 10'd1;
   localparam logic [CSR_W-1:0] WRITE_SLOT_INIT     = 10'd100;
   localparam logic [CSR_W-1:0] READ_SAMPLE_INIT    = 10'd15;
   localparam logic [CSR_W-1:0] READ_RECOVERY_INIT  = 10'd105;

   localparam logic [BITCNT_W-1:0] BYTE_BITS = 4'd8;
   localparam logic [BITCNT_W-1:0] ONE_BIT   = 4'd1;

   typedef enum logic [2:0] {
      OP_NONE       = 3'd0,
      OP_RESET      = 3'd1,
      OP_WRITE_BYTE = 3'd2,
      OP_READ_BYTE  = 3'd3,
      OP_WRITE_BIT  = 3'd4,
      OP_READ_BIT   = 3'd5
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RESET_LOW      = 3'd0,
      CSR_PRESENCE       = 3'd1,
      CSR_RESET_RECOVERY = 3'd2,
      CSR_WRITE_ONE      = 3'd3,
      CSR_WRITE_SLOT     = 3'd4,
      CSR_READ_SAMPLE    = 3'd5,
      CSR_READ_RECOVERY  = 3'd6
   } csr_idx_type;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_RESET = 4'b0010,
      PH_WRITE = 4'b0100,
      PH_READ  = 4'b1000
   } phase_type;

   // Slot timings, already forced to at least one microsecond.
   typedef struct packed {
      logic [CSR_W-1:0] reset_low;
      logic [CSR_W-1:0] presence_sample;
      logic [CSR_W-1:0] reset_recovery;
      logic [CSR_W-1:0] write_one;
      logic [CSR_W-1:0] write_slot;
      logic [CSR_W-1:0] read_sample;
      logic [CSR_W-1:0] read_recovery;
   } timing_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic       presence;
      logic [7:0] read_data;
      logic       rejected;
   } rsp_type;

endpackage

[rtl/owb_csr.sv]
// Timing register file of the one-wire bus master.
module owb_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic [owb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [owb_pkg::CSR_W-1:0]      csr_wdata,
   output owb_pkg::timing_type            timing
);

   logic [owb_pkg::CSR_W-1:0] reset_low_ff, presence_ff, reset_rec_ff;
   logic [owb_pkg::CSR_W-1:0] write_one_ff, write_slot_ff, read_sample_ff, read_rec_ff;

   function automatic logic [owb_pkg::CSR_W-1:0] at_least_one(input logic [owb_pkg::CSR_W-1:0] v);
      return (v == '0) ? owb_pkg::CSR_W'(1) : v;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_ff   <= owb_pkg::RESET_LOW_INIT;
         presence_ff    <= owb_pkg::PRESENCE_INIT;
         reset_rec_ff   <= owb_pkg::RESET_RECOVERY_INIT;
         write_one_ff   <= owb_pkg::WRITE_ONE_INIT;
         write_slot_ff  <= owb_pkg::WRITE_SLOT_INIT;
         read_sample_ff <= owb_pkg::READ_SAMPLE_INIT;
         read_rec_ff    <= owb_pkg::READ_RECOVERY_INIT;
      end else if (csr_valid) begin
         case (owb_pkg::csr_idx_type'(csr_index))
            owb_pkg::CSR_RESET_LOW:      reset_low_ff   <= csr_wdata;
            owb_pkg::CSR_PRESENCE:       presence_ff    <= csr_wdata;
            owb_pkg::CSR_RESET_RECOVERY: reset_rec_ff   <= csr_wdata;
            owb_pkg::CSR_WRITE_ONE:      write_one_ff   <= csr_wdata;
            owb_pkg::CSR_WRITE_SLOT:     write_slot_ff  <= csr_wdata;
            owb_pkg::CSR_READ_SAMPLE:    read_sample_ff <= csr_wdata;
            owb_pkg::CSR_READ_RECOVERY:  read_rec_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Treat a zero timing as one microsecond.
   always_comb begin
      timing.reset_low       = at_least_one(reset_low_ff);
      timing.presence_sample = at_least_one(presence_ff);
      timing.reset_recovery  = at_least_one(reset_rec_ff);
      timing.write_one       = at_least_one(write_one_ff);
      timing.write_slot      = at_least_one(write_slot_ff);
      timing.read_sample     = at_least_one(read_sample_ff);
      timing.read_recovery   = at_least_one(read_rec_ff);
   end

endmodule

[rtl/owb_core.sv]
// Sequencer state and per-tick step logic of the one-wire bus master.
module owb_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [2:0]           opcode,
   input  logic [7:0]           data_byte,
   input  logic                 line_level,
   input  owb_pkg::timing_type  timing,
   output owb_pkg::rsp_type     rsp
);

   owb_pkg::phase_type                 phase_ff, phase_in;
   logic [owb_pkg::TIMER_W-1:0]        slot_timer_ff, slot_timer_in;
   logic [owb_pkg::BITCNT_W-1:0]       bit_count_ff, bit_count_in;
   logic [7:0]                         shift_data_ff, shift_data_in;
   owb_pkg::op_type                    active_cmd_ff, active_cmd_in;
   logic                               presence_ff, presence_in;
   logic [7:0]                         read_hold_ff, read_hold_in;

   owb_pkg::op_type                    op;
   logic                               op_valid, start;
   owb_pkg::phase_type                 eff_phase;
   logic [owb_pkg::TIMER_W-1:0]        eff_timer;
   logic [owb_pkg::BITCNT_W-1:0]       eff_bits, bits_inc;
   logic [7:0]                         eff_shift;
   owb_pkg::op_type                    eff_cmd;
   logic                               single_bit, last_bit, finished;
   logic [owb_pkg::TIMER_W-1:0]        reset_sample_t, reset_end_t, read_end_t;
   logic [owb_pkg::CSR_W-1:0]          low_len;

   always_comb begin
      op       = owb_pkg::op_type'(opcode);
      op_valid = opcode inside {[owb_pkg::OP_RESET : owb_pkg::OP_READ_BIT]};
      start    = (phase_ff == owb_pkg::PH_IDLE) && op_valid;

      // Take a new command into the working state for this tick.
      eff_phase = phase_ff;
      eff_timer = slot_timer_ff;
      eff_bits  = bit_count_ff;
      eff_shift = shift_data_ff;
      eff_cmd   = active_cmd_ff;
      if (start) begin
         eff_timer = '0;
         eff_bits  = '0;
         eff_shift = data_byte;
         eff_cmd   = op;
         case (op)
            owb_pkg::OP_RESET:                           eff_phase = owb_pkg::PH_RESET;
            owb_pkg::OP_WRITE_BYTE, owb_pkg::OP_WRITE_BIT: eff_phase = owb_pkg::PH_WRITE;
            default:                                     eff_phase = owb_pkg::PH_READ;
         endcase
      end

      single_bit = (eff_cmd == owb_pkg::OP_WRITE_BIT) || (eff_cmd == owb_pkg::OP_READ_BIT);
      bits_inc   = eff_bits + owb_pkg::BITCNT_W'(1);
      last_bit   = single_bit ? (bits_inc >= owb_pkg::ONE_BIT) : (bits_inc >= owb_pkg::BYTE_BITS);

      reset_sample_t = owb_pkg::TIMER_W'(timing.reset_low) +
                       owb_pkg::TIMER_W'(timing.presence_sample);
      reset_end_t    = reset_sample_t + owb_pkg::TIMER_W'(timing.reset_recovery) -
                       owb_pkg::TIMER_W'(1);
      read_end_t     = owb_pkg::TIMER_W'(timing.read_sample) +
                       owb_pkg::TIMER_W'(timing.read_recovery) - owb_pkg::TIMER_W'(1);
      low_len = (eff_shift[0] && (timing.write_one < timing.write_slot)) ?
                timing.write_one : timing.write_slot;

      phase_in      = eff_phase;
      slot_timer_in = eff_timer;
      bit_count_in  = eff_bits;
      shift_data_in = eff_shift;
      active_cmd_in = eff_cmd;
      presence_in   = presence_ff;
      read_hold_in  = read_hold_ff;
      finished      = 1'b0;
      rsp.drive_low = 1'b0;

      case (eff_phase)
         owb_pkg::PH_RESET: begin
            rsp.drive_low = eff_timer < owb_pkg::TIMER_W'(timing.reset_low);
            if (eff_timer == reset_sample_t) presence_in = ~line_level;
            if (eff_timer >= reset_end_t) finished = 1'b1;
            else slot_timer_in = eff_timer + owb_pkg::TIMER_W'(1);
         end
         owb_pkg::PH_WRITE: begin
            rsp.drive_low = eff_timer < owb_pkg::TIMER_W'(low_len);
            if (eff_timer >= owb_pkg::TIMER_W'(timing.write_slot)) begin
               shift_data_in = {1'b0, eff_shift[7:1]};
               bit_count_in  = bits_inc;
               if (last_bit) finished = 1'b1;
               else slot_timer_in = '0;
            end else begin
               slot_timer_in = eff_timer + owb_pkg::TIMER_W'(1);
            end
         end
         owb_pkg::PH_READ: begin
            rsp.drive_low = eff_timer == '0;
            if (eff_timer == owb_pkg::TIMER_W'(timing.read_sample))
               shift_data_in = {line_level, eff_shift[7:1]};
            if (eff_timer >= read_end_t) begin
               bit_count_in = bits_inc;
               if (last_bit) begin
                  read_hold_in = single_bit ? {7'd0, shift_data_in[7]} : shift_data_in;
                  finished     = 1'b1;
               end else begin
                  slot_timer_in = '0;
               end
            end else begin
               slot_timer_in = eff_timer + owb_pkg::TIMER_W'(1);
            end
         end
         default: begin
         end
      endcase

      if (finished) begin
         phase_in      = owb_pkg::PH_IDLE;
         slot_timer_in = '0;
         bit_count_in  = '0;
         active_cmd_in = owb_pkg::OP_NONE;
      end

      rsp.busy_res  = eff_phase != owb_pkg::PH_IDLE;
      rsp.done_res  = finished;
      rsp.presence  = presence_in;
      rsp.read_data = read_hold_in;
      rsp.rejected  = (phase_ff != owb_pkg::PH_IDLE) && op_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= owb_pkg::PH_IDLE;
         slot_timer_ff <= '0;
         bit_count_ff  <= '0;
         shift_data_ff <= '0;
         active_cmd_ff <= owb_pkg::OP_NONE;
         presence_ff   <= 1'b0;
         read_hold_ff  <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         slot_timer_ff <= slot_timer_in;
         bit_count_ff  <= bit_count_in;
         shift_data_ff <= shift_data_in;
         active_cmd_ff <= active_cmd_in;
         presence_ff   <= presence_in;
         read_hold_ff  <= read_hold_in;
      end
   end

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      step && rsp.done_res |=> phase_ff == owb_pkg::PH_IDLE)
      else $error("sequence finished but phase did not return to idle");

   a_start_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      step && start && !rsp.done_res |=> phase_ff != owb_pkg::PH_IDLE)
      else $error("accepted command did not start a sequence");

   a_hold_without_step: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(slot_timer_ff) && $stable(phase_ff) && $stable(shift_data_ff))
      else $error("sequencer state moved without an accepted tick");

endmodule

[rtl/owb_out.sv]
// Two-entry result buffer that decouples the step logic from the result channel.
module owb_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  owb_pkg::rsp_type  in_rsp,
   output logic              full,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output owb_pkg::rsp_type  rsp
);

   logic             head_valid_ff, head_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   owb_pkg::rsp_type head_ff, head_in;
   owb_pkg::rsp_type skid_ff, skid_in;
   logic             pop;

   always_comb begin
      pop           = head_valid_ff && !rsp_stall;
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (!head_valid_ff || pop) begin
         // Refill the head from the skid entry first, else from the new item.
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            head_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            head_in       = in_rsp;
            head_valid_in = in_valid;
         end
      end else if (in_valid) begin
         skid_in       = in_rsp;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = head_valid_ff;
   assign rsp       = head_ff;

   a_skid_needs_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid entry held without a head entry");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> !skid_valid_ff)
      else $error("item pushed into a full result buffer");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && pop |=> head_valid_ff && !skid_valid_ff)
      else $error("skid entry not moved to head after a pop");

endmodule

[rtl/onewire_bus_master.sv]
// Top level of the one-wire bus master: timing registers, step logic, result buffer.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   opcode, data_byte, line_level
//   rsp      out        rsp_valid/rsp_stall   drive_low, busy_res, done_res, presence,
//                                             read_data, rejected
//   csr      in         csr_valid/csr_ready   csr_index, csr_wdata
//
// One item is one microsecond tick and is accepted every cycle while req_stall is low;
// its result is registered in the result buffer and shown from its head entry.
// The step logic between the sequencer state and the result buffer is combinational.
// Reset clears the sequencer, the result buffer and loads the default timings.
// A two-entry result buffer keeps req_stall low until two results are waiting,
// so a stall on the result side reaches the request side once the skid entry fills.
// csr_ready is always high; registers are to be written while no item is in flight,
// which the block itself does not enforce.
module onewire_bus_master (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [2:0]                     req_opcode,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_line_level,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_drive_low,
   output logic                           rsp_busy_res,
   output logic                           rsp_done_res,
   output logic                           rsp_presence,
   output logic [7:0]                     rsp_read_data,
   output logic                           rsp_rejected,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [owb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [owb_pkg::CSR_W-1:0]      csr_wdata
);

   owb_pkg::timing_type timing;
   owb_pkg::rsp_type    step_rsp;
   owb_pkg::rsp_type    out_rsp;
   logic                full;
   logic                step;

   // Advance the sequencer only on an accepted tick.
   assign step      = req_valid && !req_stall;
   assign req_stall = full;
   assign csr_ready = 1'b1;

   owb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .timing    (timing)
   );

   owb_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .opcode     (req_opcode),
      .data_byte  (req_data_byte),
      .line_level (req_line_level),
      .timing     (timing),
      .rsp        (step_rsp)
   );

   owb_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (step),
      .in_rsp    (step_rsp),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (out_rsp)
   );

   assign rsp_drive_low = out_rsp.drive_low;
   assign rsp_busy_res  = out_rsp.busy_res;
   assign rsp_done_res  = out_rsp.done_res;
   assign rsp_presence  = out_rsp.presence;
   assign rsp_read_data = out_rsp.read_data;
   assign rsp_rejected  = out_rsp.rejected;

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the one-wire bus master: directed and random tick streams.
module tb;
   import owb_pkg::*;

   // Opcodes 6 and 7 are outside the command set; the block treats them as no command.
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   // Index past the last timing register; a write to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int unsigned MAX_GAP = 11;
   localparam int unsigned STALL_LIMIT = 500;
   localparam int unsigned RANDOM_SETTINGS = 3;
   localparam int unsigned CHUNKS_PER_SETTING = 4;
   localparam int unsigned CHUNK_TICKS = 25;
   localparam int unsigned PRINT_CAP = 100;

   typedef enum {LINE_LOW, LINE_HIGH, LINE_RANDOM} line_drive_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [2:0]       req_opcode = OP_NONE;
   logic [7:0]       req_data_byte = 8'h00;
   logic             req_line_level = 1'b1;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_drive_low;
   logic             rsp_busy_res;
   logic             rsp_done_res;
   logic             rsp_presence;
   logic [7:0]       rsp_read_data;
   logic             rsp_rejected;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_RESET_LOW;
   logic [CSR_W-1:0] csr_wdata = '0;

   onewire_bus_master dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_data_byte  (req_data_byte),
      .req_line_level (req_line_level),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_drive_low  (rsp_drive_low),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_presence   (rsp_presence),
      .rsp_read_data  (rsp_read_data),
      .rsp_rejected   (rsp_rejected),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Free-running clock, period 4.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Idling knobs: when set, each side draws a random wait, bounded by MAX_GAP, before each item.
   bit send_gaps  = 1'b0;
   bit stall_gaps = 1'b0;

   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles = 0;

   // Expected result of every accepted tick, oldest first.
   rsp_type tick_results_q[$];

   // Bus sequencer mirror: timings, phase, timer, bit counter, shift register, latches.
   logic [CSR_W-1:0]    timing_reg [7];
   phase_type           seq_phase;
   logic [TIMER_W-1:0]  seq_timer;
   logic [BITCNT_W-1:0] seq_bits;
   logic [7:0]          seq_shift;
   op_type              seq_cmd;
   logic                seq_presence;
   logic [7:0]          seq_read_hold;

   task automatic reset_bus_model();
      timing_reg[CSR_RESET_LOW]      = RESET_LOW_INIT;
      timing_reg[CSR_PRESENCE]       = PRESENCE_INIT;
      timing_reg[CSR_RESET_RECOVERY] = RESET_RECOVERY_INIT;
      timing_reg[CSR_WRITE_ONE]      = WRITE_ONE_INIT;
      timing_reg[CSR_WRITE_SLOT]     = WRITE_SLOT_INIT;
      timing_reg[CSR_READ_SAMPLE]    = READ_SAMPLE_INIT;
      timing_reg[CSR_READ_RECOVERY]  = READ_RECOVERY_INIT;
      seq_phase     = PH_IDLE;
      seq_timer     = '0;
      seq_bits      = '0;
      seq_shift     = '0;
      seq_cmd       = OP_NONE;
      seq_presence  = 1'b0;
      seq_read_hold = '0;
   endtask

   // A zero timing counts as one microsecond.
   function automatic int unsigned timing_of(csr_idx_type idx);
      return (timing_reg[idx] == '0) ? 1 : int'(timing_reg[idx]);
   endfunction

   // Advance the sequencer mirror by one microsecond tick and return what the block reports.
   task automatic bus_master_tick(input logic [2:0] op, input logic [7:0] data,
                                  input logic line, output rsp_type res);
      int unsigned lo, pr, rr, ws, wo, low_len, rs, rc;
      logic valid_op, finished;
      logic [BITCNT_W-1:0] nbits;
      res = '0;
      finished = 1'b0;
      valid_op = (op >= OP_RESET) && (op <= OP_READ_BIT);
      if (seq_phase != PH_IDLE) begin
         res.rejected = valid_op;
      end else if (valid_op) begin
         seq_cmd   = op_type'(op);
         seq_timer = '0;
         seq_bits  = '0;
         seq_shift = data;
         case (seq_cmd)
            OP_RESET: seq_phase = PH_RESET;
            OP_WRITE_BYTE, OP_WRITE_BIT: seq_phase = PH_WRITE;
            default: seq_phase = PH_READ;
         endcase
      end
      if (seq_phase != PH_IDLE) begin
         nbits = (seq_cmd == OP_WRITE_BIT || seq_cmd == OP_READ_BIT) ? ONE_BIT : BYTE_BITS;
         res.busy_res = 1'b1;
         case (seq_phase)
            PH_RESET: begin
               lo = timing_of(CSR_RESET_LOW);
               pr = timing_of(CSR_PRESENCE);
               rr = timing_of(CSR_RESET_RECOVERY);
               res.drive_low = (seq_timer < lo);
               if (seq_timer == lo + pr) seq_presence = ~line;
               if (seq_timer >= lo + pr + rr - 1) finished = 1'b1;
               else seq_timer = seq_timer + 1'b1;
            end
            PH_WRITE: begin
               ws = timing_of(CSR_WRITE_SLOT);
               wo = timing_of(CSR_WRITE_ONE);
               low_len = seq_shift[0] ? ((wo < ws) ? wo : ws) : ws;
               res.drive_low = (seq_timer < low_len);
               if (seq_timer >= ws) begin
                  seq_shift = seq_shift >> 1;
                  seq_bits  = seq_bits + 1'b1;
                  if (seq_bits >= nbits) finished = 1'b1;
                  else seq_timer = '0;
               end else begin
                  seq_timer = seq_timer + 1'b1;
               end
            end
            default: begin
               rs = timing_of(CSR_READ_SAMPLE);
               rc = timing_of(CSR_READ_RECOVERY);
               res.drive_low = (seq_timer == 0);
               if (seq_timer == rs) seq_shift = {line, seq_shift[7:1]};
               if (seq_timer >= rs + rc - 1) begin
                  seq_bits = seq_bits + 1'b1;
                  if (seq_bits >= nbits) begin
                     seq_read_hold = (nbits == ONE_BIT) ? {7'b0, seq_shift[7]} : seq_shift;
                     finished = 1'b1;
                  end else begin
                     seq_timer = '0;
                  end
               end else begin
                  seq_timer = seq_timer + 1'b1;
               end
            end
         endcase
         if (finished) begin
            res.done_res = 1'b1;
            seq_phase = PH_IDLE;
            seq_timer = '0;
            seq_bits  = '0;
            seq_cmd   = OP_NONE;
         end
      end
      res.presence  = seq_presence;
      res.read_data = seq_read_hold;
   endtask

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("%0t: %s mismatch: got 'h%0h, want 'h%0h", $time, what, got, want);
   endtask

   function automatic logic pick_line(line_drive_type kind);
      case (kind)
         LINE_LOW:  return 1'b0;
         LINE_HIGH: return 1'b1;
         default:   return 1'($urandom_range(0, 1));
      endcase
   endfunction

   // Send one tick item: idle for a drawn gap, present it, hold until accepted, then
   // record its expected result. Valid stays high on return so back-to-back items
   // need no second assignment in the same step.
   task automatic send_tick(input logic [2:0] op, input logic [7:0] data, input logic line);
      int unsigned gap;
      rsp_type res;
      gap = send_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_data_byte  <= data;
      req_line_level <= line;
      do @(posedge clock); while (!(req_valid && !req_stall));
      bus_master_tick(op, data, line, res);
      tick_results_q.push_back(res);
   endtask

   // Drop valid at the next falling edge so no further item slips in.
   task automatic hold_requests();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_results_drained();
      hold_requests();
      while (tick_results_q.size() != 0) @(posedge clock);
   endtask

   // Feed empty ticks until the running command has finished.
   task automatic finish_sequence(input line_drive_type kind);
      while (seq_phase != PH_IDLE) send_tick(OP_NONE, 8'($urandom), pick_line(kind));
   endtask

   task automatic run_command(input op_type op, input logic [7:0] data,
                              input line_drive_type kind);
      send_tick(op, data, pick_line(kind));
      finish_sequence(kind);
   endtask

   // Bring the block to rest: command finished, no item in flight, pipeline settled.
   task automatic quiesce();
      finish_sequence(LINE_RANDOM);
      wait_results_drained();
      repeat (2) @(posedge clock);
   endtask

   task automatic write_timing(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      if (idx <= CSR_READ_RECOVERY) timing_reg[idx] = value;
   endtask

   task automatic program_timings(input logic [CSR_W-1:0] lo, pr, rr, wo, ws, rs, rc);
      quiesce();
      write_timing(CSR_RESET_LOW, lo);
      write_timing(CSR_PRESENCE, pr);
      write_timing(CSR_RESET_RECOVERY, rr);
      write_timing(CSR_WRITE_ONE, wo);
      write_timing(CSR_WRITE_SLOT, ws);
      write_timing(CSR_READ_SAMPLE, rs);
      write_timing(CSR_READ_RECOVERY, rc);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly short slots so many commands complete; sometimes zero or a few tens.
   function automatic logic [CSR_W-1:0] draw_timing();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 10'd1;
         2, 3, 4: return 10'($urandom_range(1, 4));
         5, 6, 7: return 10'($urandom_range(2, 12));
         default: return 10'($urandom_range(10, 40));
      endcase
   endfunction

   // Right after reset the default timings apply: one of each slot kind at full length.
   task automatic test_default_timing();
      send_gaps  = 1'b1;
      stall_gaps = 1'b1;
      repeat (3) send_tick(OP_NONE, 8'($urandom), pick_line(LINE_RANDOM));
      run_command(OP_RESET, 8'h00, LINE_LOW);
      run_command(OP_WRITE_BIT, 8'h01, LINE_RANDOM);
      run_command(OP_READ_BIT, 8'hFF, LINE_LOW);
   endtask

   // One-microsecond timings: every command, both presence answers, busy conflicts.
   task automatic test_minimum_timing();
      int code;
      program_timings(10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
      send_gaps  = 1'b1;
      stall_gaps = 1'b1;
      run_command(OP_RESET, 8'h00, LINE_HIGH);
      run_command(OP_RESET, 8'hFF, LINE_LOW);
      // skip ROM
      run_command(OP_WRITE_BYTE, 8'hCC, LINE_RANDOM);
      run_command(OP_WRITE_BYTE, 8'hFF, LINE_RANDOM);
      run_command(OP_WRITE_BYTE, 8'h00, LINE_RANDOM);
      run_command(OP_WRITE_BIT, 8'h01, LINE_RANDOM);
      run_command(OP_WRITE_BIT, 8'hFE, LINE_RANDOM);
      run_command(OP_READ_BYTE, 8'h00, LINE_RANDOM);
      run_command(OP_READ_BIT, 8'h00, LINE_HIGH);
      run_command(OP_READ_BIT, 8'hFF, LINE_LOW);
      // Every opcode from OP_RESET up while a byte write runs: commands are refused, spares are not.
      send_tick(OP_WRITE_BYTE, 8'h3C, 1'b1);
      for (code = OP_RESET; code <= OP_SPARE_HI; code++)
         send_tick(3'(code), 8'($urandom), pick_line(LINE_RANDOM));
      finish_sequence(LINE_RANDOM);
      send_tick(OP_SPARE_LO, 8'hA5, 1'b0);
      send_tick(OP_SPARE_HI, 8'h5A, 1'b1);
   endtask

   // Zero timings act as one; a write past the last register is dropped.
   task automatic test_zero_timing();
      program_timings('0, '0, '0, '0, '0, '0, '0);
      write_timing(CSR_UNUSED, 10'h3FF);
      @(negedge clock);
      csr_valid <= 1'b0;
      run_command(OP_RESET, 8'h00, LINE_LOW);
      run_command(OP_WRITE_BYTE, 8'h5A, LINE_RANDOM);
      run_command(OP_READ_BIT, 8'h00, LINE_HIGH);
   endtask

   // Write-one low time both above and below the slot length.
   task automatic test_write_one_wider();
      program_timings(10'd2, 10'd2, 10'd2, 10'd1023, 10'd3, 10'd2, 10'd2);
      run_command(OP_WRITE_BYTE, 8'hA5, LINE_RANDOM);
      program_timings(10'd3, 10'd3, 10'd3, 10'd2, 10'd6, 10'd3, 10'd3);
      run_command(OP_WRITE_BYTE, 8'h96, LINE_RANDOM);
   endtask

   // Mostly well-formed commands issued while idle, with refused commands and spare
   // opcodes mixed into busy stretches.
   task automatic send_random_tick();
      int unsigned pick;
      logic [2:0] op;
      pick = $urandom_range(0, 99);
      if (seq_phase == PH_IDLE) begin
         if (pick < 70)      op = 3'($urandom_range(OP_RESET, OP_READ_BIT));
         else if (pick < 85) op = OP_NONE;
         else                op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end else begin
         if (pick < 85)      op = OP_NONE;
         else if (pick < 93) op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
         else                op = 3'($urandom_range(OP_RESET, OP_READ_BIT));
      end
      send_tick(op, 8'($urandom), pick_line(LINE_RANDOM));
   endtask

   task automatic test_random_traffic();
      int unsigned setting, chunk, n;
      for (setting = 0; setting < RANDOM_SETTINGS; setting++) begin
         program_timings(draw_timing(), draw_timing(), draw_timing(), draw_timing(),
                         draw_timing(), draw_timing(), draw_timing());
         for (chunk = 0; chunk < CHUNKS_PER_SETTING; chunk++) begin
            // Pick an idling mix per chunk, including stretches with none at all.
            send_gaps  = 1'($urandom_range(0, 1));
            stall_gaps = 1'($urandom_range(0, 1));
            for (n = 0; n < CHUNK_TICKS; n++) send_random_tick();
            // Hold the sender now and then until every result is back.
            if (chunk % 3 == 1) wait_results_drained();
         end
      end
   endtask

   // Result side: stall for a drawn number of cycles, then take one result and check it.
   initial begin
      int unsigned hold;
      rsp_type want;
      wait (reset == 1'b0);
      forever begin
         hold = stall_gaps ? $urandom_range(0, MAX_GAP) : 0;
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         if (tick_results_q.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            want = tick_results_q.pop_front();
            if (rsp_drive_low !== want.drive_low)
               report_mismatch("drive_low", rsp_drive_low, want.drive_low);
            if (rsp_busy_res !== want.busy_res)
               report_mismatch("busy_res", rsp_busy_res, want.busy_res);
            if (rsp_done_res !== want.done_res)
               report_mismatch("done_res", rsp_done_res, want.done_res);
            if (rsp_presence !== want.presence)
               report_mismatch("presence", rsp_presence, want.presence);
            if (rsp_read_data !== want.read_data)
               report_mismatch("read_data", rsp_read_data, want.read_data);
            if (rsp_rejected !== want.rejected)
               report_mismatch("rejected", rsp_rejected, want.rejected);
         end
      end
   end

   // Watchdog: end the run if no channel moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   initial begin
      reset_bus_model();
      // Hold reset, then release it on a falling edge.
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_timing();
      test_minimum_timing();
      test_zero_timing();
      test_write_one_wider();
      test_random_traffic();

      // Drain every outstanding result, then let stragglers show up before the verdict.
      wait_results_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

[files.f]
rtl/owb_pkg.sv
rtl/owb_csr.sv
rtl/owb_core.sv
rtl/owb_out.sv
rtl/onewire_bus_master.sv
tb/sv/tb.sv
